// ===== src/rgbhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV package
// Widths and constants shared by the converter and its divider cells.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int CHANNEL_BITS      = 8;
  localparam int HUE_FRACTION_BITS = 6;
  localparam int HUE_BITS          = 15;
  localparam int SAT_BITS          = 13;
  localparam int VAL_BITS          = 8;

  localparam int SAT_ONE      = 4096;
  localparam int SAT_ONE_LOG  = 12;
  localparam int DEG_SECTOR   = 60;
  localparam int DEG_FULL     = 360;
  localparam int SECTOR_GREEN = 2;
  localparam int SECTOR_BLUE  = 4;

  localparam int HUE_UNIT = DEG_SECTOR << HUE_FRACTION_BITS;
  localparam int HUE_FULL = DEG_FULL << HUE_FRACTION_BITS;

  // Dividend widths. Saturation: 4096*delta. Hue: HUE_UNIT*|diff|.
  localparam int UNIT_BITS = $clog2(HUE_UNIT + 1);
  localparam int QUO_BITS  = SAT_ONE_LOG + CHANNEL_BITS;
  localparam int NUM_BITS  = (UNIT_BITS + CHANNEL_BITS > QUO_BITS) ?
                             UNIT_BITS + CHANNEL_BITS : QUO_BITS;
  // Quotients never exceed 4096 or HUE_UNIT, so these many bits suffice.
  localparam int QB        = (UNIT_BITS > SAT_ONE_LOG + 1) ? UNIT_BITS : SAT_ONE_LOG + 1;
  localparam int STEPS     = QB;
  localparam int HSUM_BITS = $clog2(HUE_FULL + 1) + 2;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [NUM_BITS-1:0]     num_t;
  typedef logic [QB-1:0]           quo_t;

  // Data carried along the chain beside the two divisions.
  typedef struct packed {
    chan_t             mx;
    chan_t             delta;
    logic [1:0]        sector;  // 0 red, 1 green, 2 blue
    logic              neg;
    logic              zero_d;
    num_t              s_rem;
    quo_t              s_quo;
    num_t              h_rem;
    quo_t              h_quo;
  } lane_t;

endpackage

// ===== src/rgbhsv_if.sv =====
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one beat of payload.
// ----------------------------------------------------------------------------
interface rgbhsv_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rgbhsv_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring quotient bit for both saturation and hue divisions.
// ----------------------------------------------------------------------------
module rgbhsv_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 v_in,
  input  rgbhsv_pkg::lane_t    d_in,
  input  logic [5:0]           bitpos,
  output logic                 v_out,
  output rgbhsv_pkg::lane_t    d_out
);
  import rgbhsv_pkg::*;

  lane_t nx;
  logic [NUM_BITS+QB-1:0] ms, mh;

  always_comb begin
    nx = d_in;
    ms = {{QB{1'b0}}, NUM_BITS'(d_in.mx)} << bitpos;
    mh = {{QB{1'b0}}, NUM_BITS'(d_in.delta)} << bitpos;
    if ({{QB{1'b0}}, d_in.s_rem} >= ms && d_in.mx != '0) begin
      nx.s_rem = d_in.s_rem - ms[NUM_BITS-1:0];
      nx.s_quo[bitpos[$clog2(QB)-1:0]] = 1'b1;
    end
    if ({{QB{1'b0}}, d_in.h_rem} >= mh && !d_in.zero_d) begin
      nx.h_rem = d_in.h_rem - mh[NUM_BITS-1:0];
      nx.h_quo[bitpos[$clog2(QB)-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v_out <= 1'b0;
    else if (en) v_out <= v_in;
    if (en) d_out <= nx;
  end
endmodule

// ===== src/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Front register, divider cells, output register; one pixel per cycle while
// the output is not stalled. The chain holds one quotient bit per cell.
// Reset clears the valid bits of every stage; payload is not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
  input  logic clk,
  input  logic rst,
  rgbhsv_if.sink   pix_in,
  rgbhsv_if.source hsv_out
);
  import rgbhsv_pkg::*;

  // The whole pipeline advances when the output register is free or taken.
  logic en;
  assign en = !hsv_out.valid || hsv_out.ready;
  assign pix_in.ready = en;

  // Front stage: max, min, sector and signed hue difference.
  chan_t r, g, b, mx, mn;
  logic [1:0] sec;
  logic signed [CHANNEL_BITS:0] diff;
  logic [CHANNEL_BITS-1:0] adiff;
  lane_t front;

  always_comb begin
    r = pix_in.data.red[CHANNEL_BITS-1:0];
    g = pix_in.data.green[CHANNEL_BITS-1:0];
    b = pix_in.data.blue[CHANNEL_BITS-1:0];
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    if (r == mx) begin
      sec = 2'd0; diff = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (g == mx) begin
      sec = 2'd1; diff = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      sec = 2'd2; diff = $signed({1'b0, r}) - $signed({1'b0, g});
    end
    adiff = diff[CHANNEL_BITS] ? CHANNEL_BITS'(-diff) : diff[CHANNEL_BITS-1:0];
    front.mx     = mx;
    front.delta  = mx - mn;
    front.sector = sec;
    front.neg    = diff[CHANNEL_BITS];
    front.zero_d = (mx == mn);
    front.s_rem  = num_t'(mx - mn) << SAT_ONE_LOG;
    front.s_quo  = '0;
    front.h_rem  = num_t'(adiff) * num_t'(HUE_UNIT);
    front.h_quo  = '0;
  end

  logic  v0;
  lane_t d0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= pix_in.valid;
    if (en) d0 <= front;
  end

  // Chain of cells, most significant quotient bit first.
  logic  v [STEPS+1];
  lane_t d [STEPS+1];
  assign v[0] = v0;
  assign d[0] = d0;

  for (genvar i = 0; i < STEPS; i++) begin : g_chain
    rgbhsv_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .v_in(v[i]), .d_in(d[i]),
      .bitpos(6'(STEPS - 1 - i)),
      .v_out(v[i+1]), .d_out(d[i+1])
    );
  end

  // Final stage: sector offset, sign, wrap, and zero hue for greys.
  lane_t t;
  logic signed [HSUM_BITS-1:0] h;
  always_comb begin
    t = d[STEPS];
    h = $signed(HSUM_BITS'(t.sector) * HSUM_BITS'(SECTOR_GREEN * HUE_UNIT));
    if (t.neg) h = h - $signed(HSUM_BITS'(t.h_quo));
    else h = h + $signed(HSUM_BITS'(t.h_quo));
    if (h < 0) h = h + $signed(HSUM_BITS'(HUE_FULL));
    if (t.zero_d) h = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) hsv_out.valid <= 1'b0;
    else if (en) hsv_out.valid <= v[STEPS];
    if (en) begin
      hsv_out.data.hue        <= HUE_BITS'(h);
      hsv_out.data.saturation <= SAT_BITS'(t.s_quo);
      hsv_out.data.value      <= VAL_BITS'(t.mx);
    end
  end
endmodule

// ===== sim/rgb_to_hsv_converter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Streams directed and random pixels through the converter with random gaps
// on both sides and checks each HSV beat against an in-order pixel predictor.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_test;
  import rgbhsv_pkg::*;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    logic [SAT_BITS-1:0] saturation;
    logic [VAL_BITS-1:0] value;
  } hsv_t;

  // Holds the HSV beats still owed by the converter, oldest first.
  class hsv_scoreboard;
    hsv_t owed[$];
    int   errors = 0;

    // Fixed-point conversion of one pixel.
    function hsv_t convert(pixel_t p);
      int   r, g, b, mx, mn, delta, h;
      hsv_t res;
      r = p.red;
      g = p.green;
      b = p.blue;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      h = 0;
      if (delta != 0) begin
        // SystemVerilog integer division truncates toward zero.
        if (r == mx) h = (HUE_UNIT * (g - b)) / delta;
        else if (g == mx) h = SECTOR_GREEN * HUE_UNIT + (HUE_UNIT * (b - r)) / delta;
        else h = SECTOR_BLUE * HUE_UNIT + (HUE_UNIT * (r - g)) / delta;
        if (h < 0) h += HUE_FULL;
      end
      res.hue        = h[HUE_BITS-1:0];
      res.saturation = (mx != 0) ? SAT_BITS'((SAT_ONE * delta) / mx) : '0;
      res.value      = mx[VAL_BITS-1:0];
      return res;
    endfunction

    function void note_pixel(pixel_t p);
      owed.push_back(convert(p));
    endfunction

    function void check_hsv(hsv_t got);
      hsv_t want;
      if (owed.size() == 0) begin
        $error("unexpected HSV beat hue=%0d saturation=%0d value=%0d",
               got.hue, got.saturation, got.value);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.hue !== want.hue) begin
        $error("hue: expected %0d, got %0d", want.hue, got.hue);
        errors++;
      end
      if (got.saturation !== want.saturation) begin
        $error("saturation: expected %0d, got %0d", want.saturation, got.saturation);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("value: expected %0d, got %0d", want.value, got.value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  rgbhsv_if #(.payload_t(pixel_t)) pix_in  (.clk(clk));
  rgbhsv_if #(.payload_t(hsv_t))   hsv_out (.clk(clk));

  rgb_to_hsv_converter uut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in.sink),
    .hsv_out (hsv_out.source)
  );

  hsv_scoreboard board = new();

  // When set, a side runs without gaps; this gives back-to-back stretches.
  bit pix_burst = 1'b0;
  bit hsv_burst = 1'b0;

  initial begin
    pix_in.valid  = 1'b0;
    pix_in.data   = '0;
    hsv_out.ready = 1'b0;
  end

  // Source side: an optional random gap, then one beat held until accepted.
  // The scoreboard hears of the pixel at the edge where the beat is taken.
  task automatic send_pixel(pixel_t p);
    int gap;
    gap = pix_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.data  <= p;
    do @(posedge clk); while (!pix_in.ready);
    board.note_pixel(p);
  endtask

  task automatic send_rgb(int r, int g, int b);
    pixel_t p;
    p.red   = r[CHANNEL_BITS-1:0];
    p.green = g[CHANNEL_BITS-1:0];
    p.blue  = b[CHANNEL_BITS-1:0];
    send_pixel(p);
  endtask

  // Waits at clock edges until every owed HSV beat has been checked.
  task automatic wait_drained();
    while (board.owed.size() != 0) @(posedge clk);
  endtask

  // Random pixels lean toward the corners of the colour cube: channel ties,
  // greys and extremes all change which branch of the hue logic runs.
  function automatic int pick_channel();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(0, 3);
      3:       return $urandom_range(252, 255);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic send_random_pixel();
    int r, g, b;
    r = pick_channel();
    g = pick_channel();
    b = pick_channel();
    case ($urandom_range(0, 9))
      0: g = r;          // red and green tie
      1: b = g;          // green and blue tie
      2: b = r;          // red and blue tie
      3: begin           // grey
        g = r;
        b = r;
      end
      default: ;
    endcase
    send_rgb(r, g, b);
  endtask

  // Sink side: after each beat taken, ready may drop for a random stall,
  // so stalls land on every stage of the divider chain.
  initial begin : hsv_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && hsv_out.valid && hsv_out.ready) begin
        board.check_hsv(hsv_out.data);
        stall = hsv_burst ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        hsv_out.ready <= 1'b0;
        stall--;
      end else begin
        hsv_out.ready <= 1'b1;
      end
    end
  end

  // Run-time limit, far above the slowest legal run.
  initial begin : watchdog
    #4ms;
    $display("rgb_to_hsv_converter_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pixels: black, white, greys, primaries, secondaries, the tie
    // orders between channels, and a red-led hue that wraps below zero.
    send_rgb(0, 0, 0);
    send_rgb(255, 255, 255);
    send_rgb(128, 128, 128);
    send_rgb(1, 1, 1);
    send_rgb(255, 0, 0);
    send_rgb(0, 255, 0);
    send_rgb(0, 0, 255);
    send_rgb(255, 255, 0);
    send_rgb(0, 255, 255);
    send_rgb(255, 0, 255);
    send_rgb(200, 200, 10);
    send_rgb(10, 200, 200);
    send_rgb(200, 10, 200);
    send_rgb(255, 0, 1);
    send_rgb(255, 254, 0);
    send_rgb(1, 0, 0);
    send_rgb(255, 254, 254);
    send_rgb(170, 85, 0);
    send_rgb(0, 85, 170);
    send_rgb(85, 0, 170);

    // Hold off until the pipeline has drained completely.
    pix_in.valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    for (int i = 0; i < 1750; i++) begin
      // Switch between gappy and back-to-back stretches now and then.
      if (i % 150 == 0) begin
        pix_burst = ($urandom_range(0, 2) == 0);
        hsv_burst = ($urandom_range(0, 2) == 0);
      end
      send_random_pixel();
    end
    pix_in.valid <= 1'b0;
    hsv_burst = 1'b1;

    wait_drained();
    repeat (40) @(posedge clk);

    if (board.errors == 0) begin
      $display("rgb_to_hsv_converter_test: PASS");
    end else begin
      $display("rgb_to_hsv_converter_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rgbhsv_pkg.sv
src/rgbhsv_if.sv
src/rgbhsv_cell.sv
src/rgb_to_hsv_converter.sv
sim/rgb_to_hsv_converter_test.sv
